@@ sv/tst_pkg.sv @@
// Shared types and constants for the tagged slot table.
// Used by tst_cell and tagged_slot_table; depends on nothing else.
package tst_pkg;

  localparam int MAX_SLOT_COUNT = 16;
  localparam int SLOT_W = $clog2(MAX_SLOT_COUNT);
  localparam int COUNT_W = $clog2(MAX_SLOT_COUNT + 1);
  localparam int TAG_W = 64;
  localparam int DEST_W = 4;
  localparam int OP_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_PLACE       = 3'd0,
    OP_REMOVE_SLOT = 3'd1,
    OP_REMOVE_TAG  = 3'd2,
    OP_FIND_TAG    = 3'd3,
    OP_FIND_DEST   = 3'd4,
    OP_QUERY_SLOT  = 3'd5,
    OP_CLEAR       = 3'd6
  } op_t;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    logic [TAG_W-1:0]   tag_key;
    logic [DEST_W-1:0]  destination;
    logic [COUNT_W-1:0] slot_count;
    logic               capture;
    logic               wipe;
    logic               write_en;
    logic [SLOT_W-1:0]  write_idx;
    logic               write_used;
  } cell_cmd_t;

  // Priority chain handed from each cell to the next one up.
  typedef struct packed {
    logic              tag_found;
    logic [SLOT_W-1:0] tag_idx;
    logic              dest_found;
    logic [SLOT_W-1:0] dest_idx;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
  } chain_t;

endpackage

@@ sv/tst_cell.sv @@
// One slot of the tagged slot table: occupied bit, tag and destination,
// registered match flags and its link of the lowest-match priority chain. Uses tst_pkg.
module tst_cell import tst_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [SLOT_W-1:0] cell_index,
  input  cell_cmd_t         cmd,
  input  chain_t            chain_in,
  output chain_t            chain_out,
  output logic              used,
  output logic [TAG_W-1:0]  tag,
  output logic [DEST_W-1:0] dest
);

  logic in_range;
  logic hit_tag;
  logic hit_dest;
  logic hit_free;

  assign in_range = {1'b0, cell_index} < cmd.slot_count;

  always_ff @(posedge clk) begin
    if (rst || cmd.wipe) begin
      used <= 1'b0;
      tag <= '0;
      dest <= '0;
    end else if (cmd.write_en && cmd.write_idx == cell_index) begin
      used <= cmd.write_used;
      tag <= cmd.write_used ? cmd.tag_key : '0;
      dest <= cmd.write_used ? cmd.destination : '0;
    end
  end

  // Flags are registered in the MATCH state, after the command has been registered,
  // so the wide compare has a register to itself.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_tag <= 1'b0;
      hit_dest <= 1'b0;
      hit_free <= 1'b0;
    end else if (cmd.capture) begin
      hit_tag <= used && in_range && tag == cmd.tag_key;
      hit_dest <= used && in_range && dest == cmd.destination;
      hit_free <= !used && in_range;
    end
  end

  always_comb begin
    chain_out.tag_found = chain_in.tag_found | hit_tag;
    chain_out.tag_idx = chain_in.tag_found ? chain_in.tag_idx : cell_index;
    chain_out.dest_found = chain_in.dest_found | hit_dest;
    chain_out.dest_idx = chain_in.dest_found ? chain_in.dest_idx : cell_index;
    chain_out.free_found = chain_in.free_found | hit_free;
    chain_out.free_idx = chain_in.free_found ? chain_in.free_idx : cell_index;
  end

endmodule

@@ sv/tagged_slot_table.sv @@
// Top level of the tagged slot table: command sequencer, count and output register.
// Instantiates a row of tst_cell; uses tst_pkg.
//
// Usage:
// Commands enter on the s_ stream (s_tvalid, s_tready, s_tdata) one word at a
// time; each gives exactly one result word on the m_ stream. The slot_count
// register is written on the cfg channel (cfg_valid, cfg_ready, cfg_data);
// any write empties the table. Write it only while no command is in flight.
// A command is captured when it is accepted, and its result is registered
// after the MATCH, PICK and DONE states: compare in every cell, priority
// pick along the cell chain, and update. The sequencer returns to idle as
// the result is registered, so a new command is taken only once the last
// one has left the sequencer.
// The result sits in an output register, so the next command is taken while
// the previous result waits. If the receiver stalls, the sequencer holds in
// its last step until the output register frees up, and s_tready stays low.
// Reset empties the table, clears the occupied count and the last-changed
// slot, and sets slot_count to 0, so the block reports not ready until
// slot_count is written with a value from 1 to the table size.
module tagged_slot_table import tst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [2:0] operation, [66:3] tag_key, [67] tag_present, [71:68] destination,
  // [75:72] slot_number, [76] use_preferred, [79:77] zero
  input  logic [79:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] ok, [4:1] result_slot, [68:5] stored_tag, [72:69] stored_destination,
  // [77:73] used_count, [78] is_full, [79] is_empty, [80] is_ready,
  // [84:81] last_slot, [85] last_valid, [87:86] zero
  output logic [87:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    IDLE,
    MATCH,
    PICK,
    DONE
  } state_t;

  state_t state;

  logic [COUNT_W-1:0] slot_count;
  logic [COUNT_W-1:0] used_total;
  logic [SLOT_W-1:0]  last_changed;
  logic               last_valid;

  // Registered command.
  logic [OP_W-1:0]   operation;
  logic [TAG_W-1:0]  tag_key;
  logic              tag_present;
  logic [DEST_W-1:0] destination;
  logic [SLOT_W-1:0] slot_number;
  logic              use_preferred;

  chain_t pick;

  cell_cmd_t cmd;
  chain_t    chain [0:MAX_SLOT_COUNT];
  logic [MAX_SLOT_COUNT-1:0] cell_used;
  logic [TAG_W-1:0]  cell_tag  [0:MAX_SLOT_COUNT-1];
  logic [DEST_W-1:0] cell_dest [0:MAX_SLOT_COUNT-1];

  logic cfg_write;
  logic accept;
  logic advance;
  logic rdy;
  logic snum_ok;
  logic tag_hit;
  logic dest_hit;
  logic place_ok;
  logic [SLOT_W-1:0] place_slot;
  logic [SLOT_W-1:0] rd_idx;

  logic               ok_next;
  logic [SLOT_W-1:0]  rslot_next;
  logic [TAG_W-1:0]   stag_next;
  logic [DEST_W-1:0]  sdest_next;
  logic [COUNT_W-1:0] used_total_next;
  logic [SLOT_W-1:0]  last_changed_next;
  logic               last_valid_next;
  logic               wr_en;
  logic [SLOT_W-1:0]  wr_idx;
  logic               wr_used;
  logic               wipe_op;

  assign s_tready = state == IDLE;
  assign cfg_ready = state == IDLE;
  assign accept = s_tvalid && s_tready;
  assign cfg_write = cfg_valid && cfg_ready;
  assign advance = state == DONE && (!m_tvalid || m_tready);

  assign rdy = slot_count >= COUNT_W'(1) && slot_count <= COUNT_W'(MAX_SLOT_COUNT);
  assign snum_ok = rdy && {1'b0, slot_number} < slot_count;
  assign tag_hit = rdy && tag_present && pick.tag_found;
  assign dest_hit = rdy && destination != '0 && pick.dest_found;
  assign place_slot = use_preferred ? slot_number : pick.free_idx;
  assign place_ok = rdy && destination != '0 && tag_present && !pick.tag_found &&
                    used_total < slot_count &&
                    (use_preferred ? (snum_ok && !cell_used[slot_number]) : pick.free_found);

  always_comb begin
    case (operation)
      OP_FIND_TAG:  rd_idx = pick.tag_idx;
      OP_FIND_DEST: rd_idx = pick.dest_idx;
      default:      rd_idx = slot_number;
    endcase
  end

  always_comb begin
    ok_next = 1'b0;
    rslot_next = '0;
    stag_next = '0;
    sdest_next = '0;
    used_total_next = used_total;
    last_changed_next = last_changed;
    last_valid_next = last_valid;
    wr_en = 1'b0;
    wr_idx = slot_number;
    wr_used = 1'b0;
    wipe_op = 1'b0;
    case (operation)
      OP_PLACE: begin
        if (place_ok) begin
          ok_next = 1'b1;
          rslot_next = place_slot;
          used_total_next = used_total + COUNT_W'(1);
          last_changed_next = place_slot;
          last_valid_next = 1'b1;
          wr_en = 1'b1;
          wr_idx = place_slot;
          wr_used = 1'b1;
        end
      end
      OP_REMOVE_SLOT, OP_REMOVE_TAG: begin
        if (operation == OP_REMOVE_TAG ? tag_hit : (snum_ok && cell_used[slot_number])) begin
          ok_next = 1'b1;
          rslot_next = operation == OP_REMOVE_TAG ? pick.tag_idx : slot_number;
          used_total_next = used_total == '0 ? '0 : used_total - COUNT_W'(1);
          last_changed_next = rslot_next;
          last_valid_next = 1'b1;
          wr_en = 1'b1;
          wr_idx = rslot_next;
        end
      end
      OP_FIND_TAG, OP_FIND_DEST, OP_QUERY_SLOT: begin
        if ((operation == OP_FIND_TAG && tag_hit) ||
            (operation == OP_FIND_DEST && dest_hit) ||
            (operation == OP_QUERY_SLOT && snum_ok && cell_used[slot_number])) begin
          ok_next = 1'b1;
          rslot_next = rd_idx;
          stag_next = cell_tag[rd_idx];
          sdest_next = cell_dest[rd_idx];
        end
      end
      OP_CLEAR: begin
        ok_next = 1'b1;
        used_total_next = '0;
        last_changed_next = '0;
        last_valid_next = 1'b0;
        wipe_op = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cmd.tag_key = tag_key;
    cmd.destination = destination;
    cmd.slot_count = slot_count;
    cmd.capture = state == MATCH;
    cmd.wipe = cfg_write || (advance && wipe_op);
    cmd.write_en = advance && wr_en;
    cmd.write_idx = wr_idx;
    cmd.write_used = wr_used;
  end

  assign chain[0] = '0;

  for (genvar i = 0; i < MAX_SLOT_COUNT; i++) begin : g_cell
    tst_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_index (SLOT_W'(i)),
      .cmd        (cmd),
      .chain_in   (chain[i]),
      .chain_out  (chain[i+1]),
      .used       (cell_used[i]),
      .tag        (cell_tag[i]),
      .dest       (cell_dest[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      slot_count <= '0;
      used_total <= '0;
      last_changed <= '0;
      last_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !advance) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_write) begin
        slot_count <= cfg_data;
        used_total <= '0;
        last_changed <= '0;
        last_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            state <= MATCH;
          end
        end
        MATCH: state <= PICK;
        PICK:  state <= DONE;
        DONE: begin
          if (advance) begin
            state <= IDLE;
            used_total <= used_total_next;
            last_changed <= last_changed_next;
            last_valid <= last_valid_next;
            m_tvalid <= 1'b1;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      operation <= s_tdata[2:0];
      tag_key <= s_tdata[66:3];
      tag_present <= s_tdata[67];
      destination <= s_tdata[71:68];
      slot_number <= s_tdata[75:72];
      use_preferred <= s_tdata[76];
    end
    if (state == PICK) begin
      pick <= chain[MAX_SLOT_COUNT];
    end
    if (advance) begin
      m_tdata <= {2'b00,
                  last_valid_next,
                  last_valid_next ? last_changed_next : {SLOT_W{1'b0}},
                  rdy,
                  rdy && used_total_next == '0,
                  rdy && used_total_next >= slot_count,
                  used_total_next,
                  sdest_next,
                  stag_next,
                  rslot_next,
                  ok_next};
    end
  end

endmodule
